[rtl/core/tcptmr_pkg.sv]
// Package for the socket timer table: widths, codes, FSM state and
// controller/datapath command and status types. No dependencies.
package tcptmr_pkg;

  localparam int SOCKETS_DEF = 16;

  localparam int FUNC_W  = 3;
  localparam int SOCK_W  = 4;
  localparam int RES_W   = 2;
  localparam int ATT_W   = 3;
  localparam int TMR_W   = 32;
  localparam int STEP_W  = 16;
  localparam int TWL_W   = 31;
  localparam int BASE_W  = 24;
  localparam int CFG_IW  = 2;
  localparam int CFG_DW  = 31;

  localparam logic [FUNC_W-1:0] FN_TICK   = 3'd0;
  localparam logic [FUNC_W-1:0] FN_TW_ARM = 3'd1;
  localparam logic [FUNC_W-1:0] FN_TW_RST = 3'd2;
  localparam logic [FUNC_W-1:0] FN_RT_ARM = 3'd3;
  localparam logic [FUNC_W-1:0] FN_RT_RST = 3'd4;
  localparam logic [FUNC_W-1:0] FN_RT_CLS = 3'd5;

  localparam logic [RES_W-1:0] EV_RELEASE = 2'd0;
  localparam logic [RES_W-1:0] EV_RETRANS = 2'd1;
  localparam logic [RES_W-1:0] EV_GIVEUP  = 2'd2;

  localparam logic [CFG_IW-1:0] CFG_TICK_STEP = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_TW_LOAD   = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_RT_BASE   = 2'd2;
  localparam logic [CFG_IW-1:0] CFG_MAX_RETRY = 2'd3;

  localparam logic [STEP_W-1:0] TICK_STEP_RST = 16'd1;
  localparam logic [TWL_W-1:0]  TW_LOAD_RST   = 31'd1000;
  localparam logic [BASE_W-1:0] RT_BASE_RST   = 24'd200;
  localparam logic [ATT_W-1:0]  MAX_RETRY_RST = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_TW,
    ST_RT,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic start;
    logic cmd_do;
    logic tw_do;
    logic rt_do;
    logic flush;
  } ctl_t;

  typedef struct packed {
    logic push_ok;
    logic idx_last;
  } sts_t;

endpackage

[rtl/core/tcptmr_cmd_if.sv]
// Command channel: valid/ready handshake carrying func and sock_index.
// Depends on tcptmr_pkg for field widths.
interface tcptmr_cmd_if;
  logic                             valid;
  logic                             ready;
  logic [tcptmr_pkg::FUNC_W-1:0]    func;
  logic [tcptmr_pkg::SOCK_W-1:0]    sock_index;

  modport source (output valid, output func, output sock_index, input ready);
  modport sink   (input valid, input func, input sock_index, output ready);
endinterface

[rtl/core/tcptmr_evt_if.sv]
// Event channel: valid/ready handshake carrying one timer event word.
// Depends on tcptmr_pkg for field widths.
interface tcptmr_evt_if;
  logic                            valid;
  logic                            ready;
  logic [tcptmr_pkg::RES_W-1:0]    event_res;
  logic [tcptmr_pkg::SOCK_W-1:0]   event_sock;
  logic [tcptmr_pkg::ATT_W-1:0]    attempt;
  logic                            last;

  modport source (output valid, output event_res, output event_sock, output attempt,
                  output last, input ready);
  modport sink   (input valid, input event_res, input event_sock, input attempt,
                  input last, output ready);
endinterface

[rtl/core/tcptmr_ctrl.sv]
// Sequencer for the timer table: accepts commands and steps a tick scan
// through the slots. Depends on tcptmr_pkg.
module tcptmr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_tick,
  output logic               in_ready,
  output tcptmr_pkg::ctl_t   ctl,
  input  tcptmr_pkg::sts_t   sts
);

  tcptmr_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcptmr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    ctl        = '0;
    unique case (state)
      tcptmr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_tick) begin
            ctl.start  = 1'b1;
            state_next = tcptmr_pkg::ST_READ;
          end else begin
            ctl.cmd_do = 1'b1;
          end
        end
      end
      tcptmr_pkg::ST_READ: begin
        state_next = tcptmr_pkg::ST_TW;
      end
      tcptmr_pkg::ST_TW: begin
        ctl.tw_do = 1'b1;
        if (sts.push_ok) state_next = tcptmr_pkg::ST_RT;
      end
      tcptmr_pkg::ST_RT: begin
        ctl.rt_do = 1'b1;
        if (sts.push_ok) begin
          state_next = sts.idx_last ? tcptmr_pkg::ST_FLUSH : tcptmr_pkg::ST_READ;
        end
      end
      tcptmr_pkg::ST_FLUSH: begin
        ctl.flush = 1'b1;
        if (sts.push_ok) state_next = tcptmr_pkg::ST_IDLE;
      end
      default: begin
        state_next = tcptmr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/tcptmr_dp.sv]
// Datapath for the timer table: config registers, slot memories, active
// bits, timer arithmetic and the event holding/output registers.
// Depends on tcptmr_pkg and tcptmr_evt_if.
module tcptmr_dp #(
  parameter int SOCKETS = tcptmr_pkg::SOCKETS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [tcptmr_pkg::CFG_IW-1:0]     cfg_index,
  input  logic [tcptmr_pkg::CFG_DW-1:0]     cfg_data,
  input  logic [tcptmr_pkg::FUNC_W-1:0]     func,
  input  logic [tcptmr_pkg::SOCK_W-1:0]     sock_index,
  input  tcptmr_pkg::ctl_t                  ctl,
  output tcptmr_pkg::sts_t                  sts,
  tcptmr_evt_if.source                      evt
);

  localparam int SW = (SOCKETS > 1) ? $clog2(SOCKETS) : 1;
  localparam int TW = tcptmr_pkg::TMR_W;
  localparam int AW = tcptmr_pkg::ATT_W;

  // config
  logic [tcptmr_pkg::STEP_W-1:0] tick_step;
  logic [tcptmr_pkg::TWL_W-1:0]  timewait_load;
  logic [tcptmr_pkg::BASE_W-1:0] retrans_base;
  logic [AW-1:0]                 max_retries;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_step     <= tcptmr_pkg::TICK_STEP_RST;
      timewait_load <= tcptmr_pkg::TW_LOAD_RST;
      retrans_base  <= tcptmr_pkg::RT_BASE_RST;
      max_retries   <= tcptmr_pkg::MAX_RETRY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tcptmr_pkg::CFG_TICK_STEP: tick_step     <= cfg_data[tcptmr_pkg::STEP_W-1:0];
        tcptmr_pkg::CFG_TW_LOAD:   timewait_load <= cfg_data[tcptmr_pkg::TWL_W-1:0];
        tcptmr_pkg::CFG_RT_BASE:   retrans_base  <= cfg_data[tcptmr_pkg::BASE_W-1:0];
        tcptmr_pkg::CFG_MAX_RETRY: max_retries   <= cfg_data[AW-1:0];
        default: ;
      endcase
    end
  end

  // slot state
  logic [TW-1:0] tw_mem  [SOCKETS];
  logic [TW-1:0] rt_mem  [SOCKETS];
  logic [AW-1:0] cnt_mem [SOCKETS];
  logic [SOCKETS-1:0] tw_act, rt_act;

  logic [SW-1:0] idx;
  logic [TW-1:0] rd_tw, rd_rt;
  logic [AW-1:0] rd_cnt;

  logic [SW-1:0] cmd_slot;
  logic          cmd_ok;
  assign cmd_slot = SW'(sock_index);
  assign cmd_ok   = ctl.cmd_do && (32'(sock_index) < SOCKETS);

  // event holding and output registers
  logic          pend_valid;
  logic [1:0]    pend_res;
  logic [SW-1:0] pend_sock;
  logic [AW-1:0] pend_att;
  logic          out_valid;

  logic push_ok;
  assign push_ok      = !pend_valid || !out_valid || evt.ready;
  assign sts.push_ok  = push_ok;
  assign sts.idx_last = (idx == SW'(SOCKETS - 1));

  // time-wait step
  logic [TW-1:0] tw_new;
  logic          tw_exp;
  logic          tw_go;
  assign tw_new = rd_tw - TW'(tick_step);
  assign tw_exp = (tw_new == '0) || tw_new[TW-1];
  assign tw_go  = ctl.tw_do && push_ok && tw_act[idx];

  // retransmission step
  logic [TW-1:0] rt_new;
  logic          rt_exp;
  logic          rt_go;
  logic [AW:0]   cnt_inc;
  logic          retry;
  logic [AW-1:0] att_new;
  assign rt_new  = rd_rt - TW'(tick_step);
  assign rt_exp  = (rt_new == '0) || rt_new[TW-1];
  assign rt_go   = ctl.rt_do && push_ok && rt_act[idx];
  assign cnt_inc = {1'b0, rd_cnt} + 1'b1;
  assign retry   = (cnt_inc <= {1'b0, max_retries});
  assign att_new = cnt_inc[AW] ? '1 : cnt_inc[AW-1:0];

  logic          ev_push;
  logic [1:0]    ev_res;
  logic [AW-1:0] ev_att;

  always_comb begin
    ev_push = 1'b0;
    ev_res  = tcptmr_pkg::EV_RELEASE;
    ev_att  = '0;
    if (tw_go && tw_exp) begin
      ev_push = 1'b1;
    end else if (rt_go && rt_exp) begin
      ev_push = 1'b1;
      ev_res  = retry ? tcptmr_pkg::EV_RETRANS : tcptmr_pkg::EV_GIVEUP;
      ev_att  = att_new;
    end
  end

  always_ff @(posedge clk) begin
    rd_tw  <= tw_mem[idx];
    rd_rt  <= rt_mem[idx];
    rd_cnt <= cnt_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (cmd_ok && (func == tcptmr_pkg::FN_TW_ARM || func == tcptmr_pkg::FN_TW_RST)) begin
      tw_mem[cmd_slot] <= TW'(timewait_load);
    end else if (tw_go) begin
      tw_mem[idx] <= tw_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_ok && (func == tcptmr_pkg::FN_RT_ARM || func == tcptmr_pkg::FN_RT_RST)) begin
      rt_mem[cmd_slot]  <= TW'(retrans_base);
      cnt_mem[cmd_slot] <= '0;
    end else if (rt_go) begin
      if (rt_exp) begin
        cnt_mem[idx] <= att_new;
        rt_mem[idx]  <= retry ? (TW'(retrans_base) << cnt_inc[AW-1:0]) : rt_new;
      end else begin
        rt_mem[idx] <= rt_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tw_act <= '0;
      rt_act <= '0;
    end else if (cmd_ok) begin
      unique case (func)
        tcptmr_pkg::FN_TW_ARM: tw_act[cmd_slot] <= 1'b1;
        tcptmr_pkg::FN_RT_ARM: rt_act[cmd_slot] <= 1'b1;
        tcptmr_pkg::FN_RT_CLS: rt_act[cmd_slot] <= 1'b0;
        default: ;
      endcase
    end else begin
      if (tw_go && tw_exp) tw_act[idx] <= 1'b0;
      if (rt_go && rt_exp && !retry) rt_act[idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      idx <= '0;
    end else if (ctl.rt_do && push_ok) begin
      idx <= idx + 1'b1;
    end
  end

  logic out_load, out_last_in;
  assign out_load    = pend_valid && ((ev_push) || (ctl.flush && push_ok));
  assign out_last_in = ctl.flush;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (ev_push) begin
        pend_valid <= 1'b1;
      end else if (ctl.flush && push_ok) begin
        pend_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (evt.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ev_push) begin
      pend_res  <= ev_res;
      pend_sock <= idx;
      pend_att  <= ev_att;
    end
    if (out_load) begin
      evt.event_res  <= pend_res;
      evt.event_sock <= tcptmr_pkg::SOCK_W'(pend_sock);
      evt.attempt    <= pend_att;
      evt.last       <= out_last_in;
    end
  end

  assign evt.valid = out_valid;

  a_flush_last: assert property (@(posedge clk) disable iff (rst)
    (ctl.flush && push_ok && pend_valid) |=> (evt.valid && evt.last))
    else $error("flushed event not marked last");

  a_flush_empty: assert property (@(posedge clk) disable iff (rst)
    (ctl.flush && push_ok) |=> !pend_valid)
    else $error("event left pending after scan");

  a_start_clean: assert property (@(posedge clk) disable iff (rst)
    ctl.start |-> !pend_valid)
    else $error("scan started with stale pending event");

  a_release_att: assert property (@(posedge clk) disable iff (rst)
    (evt.valid && evt.event_res == tcptmr_pkg::EV_RELEASE) |-> (evt.attempt == '0))
    else $error("release event carries attempt count");

endmodule

[rtl/core/tcp_timewait_retransmit_timer_table_top.sv]
// Socket timer table: a time-wait and a retransmission timer for each slot,
// with exponential backoff. Command words (arm, restart, close) are applied
// when accepted in the idle state. A tick word scans the slots in ascending
// order, the sequencer stepping each slot through read, time-wait and
// retransmission states over a single registered read port, then a flush
// state; a stalled event output holds the scan. Event words come out in
// slot order, the time-wait event of a slot before its retransmission
// event, and the final event of a tick has last set. Registers: index 0
// tick_step, 1 timewait_load, 2 retrans_base, 3 max_retries.
module tcp_timewait_retransmit_timer_table_top #(
  parameter int SOCKETS = tcptmr_pkg::SOCKETS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  tcptmr_cmd_if.sink                      cmd,
  tcptmr_evt_if.source                    evt,
  input  logic                            cfg_we,
  input  logic [tcptmr_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [tcptmr_pkg::CFG_DW-1:0]   cfg_data
);

  tcptmr_pkg::ctl_t ctl;
  tcptmr_pkg::sts_t sts;

  tcptmr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.valid),
    .in_tick  (cmd.func == tcptmr_pkg::FN_TICK),
    .in_ready (cmd.ready),
    .ctl      (ctl),
    .sts      (sts)
  );

  tcptmr_dp #(
    .SOCKETS (SOCKETS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .func       (cmd.func),
    .sock_index (cmd.sock_index),
    .ctl        (ctl),
    .sts        (sts),
    .evt        (evt)
  );

endmodule
